// File: rtl/dual_led_pulse_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// dual_led_pulse_encoder_unit_assert.svh
// assertion macros used by the pulse encoder serializer
// ----------------------------------------------------------------------------
`ifndef DUAL_LED_PULSE_ENCODER_UNIT_ASSERT_SVH
`define DUAL_LED_PULSE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DLPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlpe check failed");

// next-cycle implication, checked out of reset
`define DLPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlpe check failed");

`endif

// File: rtl/dlpe_pkg.sv
// ----------------------------------------------------------------------------
// dlpe_pkg
// shared constants and types of the dual led pulse encoder
// ----------------------------------------------------------------------------
package dlpe_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COLOUR_W   = 24;
  localparam int unsigned NUM_LANES  = 6;
  localparam int unsigned NUM_PULSES = NUM_LANES * BYTE_W;
  localparam int unsigned CNT_W      = $clog2(NUM_PULSES);
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] LAST_PULSE = CNT_W'(NUM_PULSES - 1);

  localparam logic [BYTE_W-1:0] CEILING_RESET = 8'd40;
  localparam logic [BYTE_W-1:0] LONG_RESET    = 8'd8;
  localparam logic [BYTE_W-1:0] SHORT_RESET   = 8'd4;

  // byte position of g, r, b inside 0xrrggbb
  localparam int unsigned CH_SHIFT [3] = '{8, 16, 0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CEILING = 2'd0,
    CFG_LONG    = 2'd1,
    CFG_SHORT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic free;
  } ser_status_t;

endpackage

// File: rtl/dlpe_scale.sv
// ----------------------------------------------------------------------------
// dlpe_scale
// six parallel lanes scaling each channel byte to byte*ceiling/255
// ----------------------------------------------------------------------------
module dlpe_scale (
  input  logic [dlpe_pkg::COLOUR_W-1:0]   colour_first,
  input  logic [dlpe_pkg::COLOUR_W-1:0]   colour_second,
  input  logic [dlpe_pkg::BYTE_W-1:0]     ceiling,
  output logic [dlpe_pkg::NUM_PULSES-1:0] frame
);

  // floor(p/255) as (p + p/256 + 1)/256, exact for p up to 255*255
  function automatic logic [dlpe_pkg::BYTE_W-1:0] scale_byte(
    input logic [dlpe_pkg::BYTE_W-1:0] value,
    input logic [dlpe_pkg::BYTE_W-1:0] ceil_v
  );
    logic [2*dlpe_pkg::BYTE_W-1:0] prod;
    logic [2*dlpe_pkg::BYTE_W:0]   sum;
    prod = value * ceil_v;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  for (genvar i = 0; i < dlpe_pkg::NUM_LANES; i++) begin : g_lane
    localparam int unsigned SH = dlpe_pkg::CH_SHIFT[i % 3];
    logic [dlpe_pkg::COLOUR_W-1:0] colour;
    logic [dlpe_pkg::BYTE_W-1:0]   chan;
    assign colour = (i < 3) ? colour_first : colour_second;
    assign chan   = colour[SH +: dlpe_pkg::BYTE_W];
    assign frame[dlpe_pkg::NUM_PULSES-1-dlpe_pkg::BYTE_W*i -: dlpe_pkg::BYTE_W] =
      scale_byte(chan, ceiling);
  end

endmodule

// File: rtl/dlpe_serializer.sv
// ----------------------------------------------------------------------------
// dlpe_serializer
// shifts a 48-bit frame out msb first, one pulse word per cycle on out_ready
// ----------------------------------------------------------------------------
`include "dual_led_pulse_encoder_unit_assert.svh"

module dlpe_serializer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [dlpe_pkg::NUM_PULSES-1:0] frame,
  input  logic [dlpe_pkg::BYTE_W-1:0]     long_ticks,
  input  logic [dlpe_pkg::BYTE_W-1:0]     short_ticks,
  output dlpe_pkg::ser_status_t           status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_data_bit,
  output logic [dlpe_pkg::BYTE_W-1:0]     out_high_ticks,
  output logic [dlpe_pkg::BYTE_W-1:0]     out_low_ticks,
  output logic                            out_frame_end
);

  logic [dlpe_pkg::NUM_PULSES-1:0] shift_r, shift_nxt;
  logic [dlpe_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            active_r, active_nxt;
  logic                            last;

  assign last        = (cnt_r == dlpe_pkg::LAST_PULSE);
  assign status.free = !active_r || (out_ready && last);

  always_comb begin
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    if (load) begin
      shift_nxt  = frame;
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r && out_ready) begin
      shift_nxt  = shift_r << 1;
      cnt_nxt    = cnt_r + 1'b1;
      active_nxt = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
    shift_r <= shift_nxt;
  end

  assign out_valid      = active_r;
  assign out_data_bit   = shift_r[dlpe_pkg::NUM_PULSES-1];
  assign out_high_ticks = out_data_bit ? long_ticks : short_ticks;
  assign out_low_ticks  = out_data_bit ? short_ticks : long_ticks;
  assign out_frame_end  = last;

  `DLPE_ASSERT_NOW(a_load_when_free, load, status.free)
  `DLPE_ASSERT_NOW(a_cnt_in_range, active_r, cnt_r <= dlpe_pkg::LAST_PULSE)
  `DLPE_ASSERT_NEXT(a_frame_done, active_r && out_ready && last && !load, !active_r)

endmodule

// File: rtl/dual_led_pulse_encoder_unit.sv
// ----------------------------------------------------------------------------
// dual_led_pulse_encoder_unit
// turns a pair of led colours into 48 scaled grb bit pulses
//
//   channel | ports                         | word
//   --------+-------------------------------+-----------------------------
//   in      | in_valid / in_ready           | colour_first, colour_second
//   out     | out_valid / out_ready         | data_bit, ticks, frame_end
//   cfg     | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// a pair waits in the input register until the serializer is free, then
// scales in one pass into the 48-bit serializer, which gives one pulse per
// cycle while out_ready is high and so sets the pace of new pairs. a
// repeated pair is dropped. the next pair is taken while a frame shifts out;
// out_ready low holds the current pulse. synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module dual_led_pulse_encoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dlpe_pkg::COLOUR_W-1:0]  in_colour_first,
  input  logic [dlpe_pkg::COLOUR_W-1:0]  in_colour_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_data_bit,
  output logic [dlpe_pkg::BYTE_W-1:0]    out_high_ticks,
  output logic [dlpe_pkg::BYTE_W-1:0]    out_low_ticks,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlpe_pkg::BYTE_W-1:0]    cfg_data
);

  logic [dlpe_pkg::COLOUR_W-1:0]   hold_first_r, hold_second_r;
  logic                            hold_valid_r, hold_valid_nxt;
  logic [dlpe_pkg::COLOUR_W-1:0]   prev_first_r, prev_second_r;
  logic                            prev_valid_r;
  logic [dlpe_pkg::BYTE_W-1:0]     ceiling_r, long_r, short_r;
  logic [dlpe_pkg::NUM_PULSES-1:0] frame;
  dlpe_pkg::ser_status_t           ser_status;
  logic                            repeat_pair, take, load, in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= dlpe_pkg::CEILING_RESET;
      long_r    <= dlpe_pkg::LONG_RESET;
      short_r   <= dlpe_pkg::SHORT_RESET;
    end else if (cfg_valid) begin
      case (dlpe_pkg::cfg_idx_t'(cfg_index))
        dlpe_pkg::CFG_CEILING: ceiling_r <= cfg_data;
        dlpe_pkg::CFG_LONG:    long_r    <= cfg_data;
        dlpe_pkg::CFG_SHORT:   short_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign repeat_pair = prev_valid_r && (prev_first_r == hold_first_r)
                       && (prev_second_r == hold_second_r);
  assign take        = hold_valid_r && (repeat_pair || ser_status.free);
  assign load        = hold_valid_r && !repeat_pair && ser_status.free;
  assign in_ready    = !hold_valid_r || take;
  assign in_fire     = in_valid && in_ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      prev_valid_r <= 1'b0;
      prev_first_r <= '0;
      prev_second_r <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      if (load) begin
        prev_valid_r  <= 1'b1;
        prev_first_r  <= hold_first_r;
        prev_second_r <= hold_second_r;
      end
    end
    if (in_fire) begin
      hold_first_r  <= in_colour_first;
      hold_second_r <= in_colour_second;
    end
  end

  dlpe_scale u_scale (
    .colour_first  (hold_first_r),
    .colour_second (hold_second_r),
    .ceiling       (ceiling_r),
    .frame         (frame)
  );

  dlpe_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .frame          (frame),
    .long_ticks     (long_r),
    .short_ticks    (short_r),
    .status         (ser_status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_bit   (out_data_bit),
    .out_high_ticks (out_high_ticks),
    .out_low_ticks  (out_low_ticks),
    .out_frame_end  (out_frame_end)
  );

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression bench for the dual led pulse encoder
//
// colour pairs go in through a valid/ready channel. Each one is a directed
// table row or a random pair. A bench-side model scales every channel byte
// and expands each new pair into 48 grb pulses, then checks every pulse word
// that comes out. Register settings change between phases, only while the
// block is idle. Sender bursts and receiver stalls are random, and one long
// receiver hold-off backs the block up to its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dlpe_pkg::*;

  localparam int unsigned  PAIR_TARGET  = 430;
  localparam int unsigned  CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned  DRAIN_SLACK  = 8;
  localparam int unsigned  HOLD_AT      = 60;
  localparam int unsigned  HOLD_CYCLES  = 400;
  localparam logic [7:0]   STALL_PAT    = 8'b0100_1001;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic              data_bit;
    logic [BYTE_W-1:0] high_ticks;
    logic [BYTE_W-1:0] low_ticks;
    logic              frame_end;
  } pulse_t;

  typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [BYTE_W-1:0]      reg_val;
    logic [COLOUR_W-1:0]    first;
    logic [COLOUR_W-1:0]    second;
    logic                   typed;
    logic                   has_frame;
    logic [NUM_PULSES-1:0]  bits;
  } row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_CHOKED} rx_mode_t;

  localparam int unsigned NUM_ROWS = 32;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h000000, 24'h000000, 1'b1, 1'b1, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h000000, 24'h000000, 1'b1, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 48'h282828282828},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h123456, 24'hABCDEF, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_CEILING, 8'hFF, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 48'hFFFFFFFFFFFF},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h800001, 24'h010080, 1'b1, 1'b1, 48'h008001000180},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFFFFFF, 24'hFFFFFE, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_CEILING, 8'h00, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hA5A5A5, 24'h5A5A5A, 1'b1, 1'b1, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hA5A5A5, 24'h5A5A5A, 1'b1, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_CEILING, 8'hFF, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_LONG,    8'hFF, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_SHORT,   8'h01, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h0F0F0F, 24'hF0F0F0, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_LONG,    8'h00, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_SHORT,   8'h00, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFF00FF, 24'h00FF00, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_LONG,    8'h01, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_SHORT,   8'hFF, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h55AA55, 24'hAA55AA, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_SPARE,   8'h00, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h3C3C3C, 24'hC3C3C3, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_REG,  CFG_CEILING, 8'h80, 24'h000000, 24'h000000, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'hFFFFFF, 24'h010101, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h7F7F7F, 24'h808080, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h7F7F7F, 24'h808080, 1'b1, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h7F7F7E, 24'h808080, 1'b0, 1'b0, 48'h000000000000},
    '{ROW_PAIR, CFG_CEILING, 8'h00, 24'h7F7F7F, 24'h808080, 1'b0, 1'b0, 48'h000000000000}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COLOUR_W-1:0]  in_colour_first = '0;
  logic [COLOUR_W-1:0]  in_colour_second = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_data_bit;
  logic [BYTE_W-1:0]    out_high_ticks;
  logic [BYTE_W-1:0]    out_low_ticks;
  logic                 out_frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  dual_led_pulse_encoder_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_colour_first  (in_colour_first),
    .in_colour_second (in_colour_second),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_bit     (out_data_bit),
    .out_high_ticks   (out_high_ticks),
    .out_low_ticks    (out_low_ticks),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // encoder model state
  logic [BYTE_W-1:0]   cur_ceiling = CEILING_RESET;
  logic [BYTE_W-1:0]   cur_long    = LONG_RESET;
  logic [BYTE_W-1:0]   cur_short   = SHORT_RESET;
  logic [COLOUR_W-1:0] sent_first  = '0;
  logic [COLOUR_W-1:0] sent_second = '0;
  logic                sent_any    = 1'b0;

  pulse_t pulse_q [$];

  // typed expectation of the current table row
  logic                  row_typed     = 1'b0;
  logic                  row_has_frame = 1'b0;
  logic [NUM_PULSES-1:0] row_bits      = '0;

  int unsigned errors       = 0;
  int unsigned pairs_taken  = 0;
  int unsigned frames_taken = 0;
  int unsigned repeats_seen = 0;
  int unsigned pulses_seen  = 0;
  int unsigned reg_writes   = 0;

  // sender state
  logic [COLOUR_W-1:0] last_first  = '0;
  logic [COLOUR_W-1:0] last_second = '0;
  int unsigned         burst_left  = 0;

  function automatic logic [BYTE_W-1:0] scale_channel(input logic [BYTE_W-1:0] chan);
    logic [15:0] prod;
    prod = 16'(chan) * 16'(cur_ceiling);
    return BYTE_W'(prod / 16'd255);
  endfunction

  // g, r, b of the first led then the second, msb first
  function automatic logic [NUM_PULSES-1:0] frame_bits(input logic [COLOUR_W-1:0] a,
                                                       input logic [COLOUR_W-1:0] b);
    return {scale_channel(a[15:8]), scale_channel(a[23:16]), scale_channel(a[7:0]),
            scale_channel(b[15:8]), scale_channel(b[23:16]), scale_channel(b[7:0])};
  endfunction

  function automatic void queue_frame(input logic [NUM_PULSES-1:0] bits);
    pulse_t p;
    for (int i = NUM_PULSES - 1; i >= 0; i--) begin
      p.data_bit   = bits[i];
      p.high_ticks = bits[i] ? cur_long : cur_short;
      p.low_ticks  = bits[i] ? cur_short : cur_long;
      p.frame_end  = (i == 0);
      pulse_q.push_back(p);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d pulses still expected", cycles,
                 pulse_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    pulse_t want;
    logic   is_repeat;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_CEILING: cur_ceiling = cfg_data;
          CFG_LONG:    cur_long    = cfg_data;
          CFG_SHORT:   cur_short   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pairs_taken++;
        is_repeat = sent_any && in_colour_first == sent_first &&
                    in_colour_second == sent_second;
        if (row_typed) begin
          if (row_has_frame) queue_frame(row_bits);
        end else if (!is_repeat) begin
          queue_frame(frame_bits(in_colour_first, in_colour_second));
        end
        if (is_repeat) begin
          repeats_seen++;
        end else begin
          frames_taken++;
          sent_first  = in_colour_first;
          sent_second = in_colour_second;
          sent_any    = 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        pulses_seen++;
        if (pulse_q.size() == 0) begin
          errors++;
          $error("pulse word with nothing expected");
        end else begin
          want = pulse_q.pop_front();
          if (out_data_bit !== want.data_bit) begin
            errors++;
            $error("data_bit: expected %0d, got %0d", want.data_bit, out_data_bit);
          end
          if (out_high_ticks !== want.high_ticks) begin
            errors++;
            $error("high_ticks: expected %0d, got %0d", want.high_ticks, out_high_ticks);
          end
          if (out_low_ticks !== want.low_ticks) begin
            errors++;
            $error("low_ticks: expected %0d, got %0d", want.low_ticks, out_low_ticks);
          end
          if (out_frame_end !== want.frame_end) begin
            errors++;
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
          end
        end
      end
    end
  end

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned span;
    int unsigned hold_left;
    logic [2:0]  pat_pos;
    logic        hold_done;
    mode      = RX_OPEN;
    span      = 0;
    hold_left = 0;
    pat_pos   = '0;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && frames_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(16, 160);
        end
        span--;
        pat_pos++;
        case (mode)
          RX_OPEN:    out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ready <= ~STALL_PAT[pat_pos];
          RX_CHOKED:  out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= 1'b1;
        endcase
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_pair(input logic [COLOUR_W-1:0] a, input logic [COLOUR_W-1:0] b);
    int unsigned gap;
    in_colour_first  <= a;
    in_colour_second <= b;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    last_first  = a;
    last_second = b;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and let every expected pulse word come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pulse_q.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [COLOUR_W-1:0] a;
    logic [COLOUR_W-1:0] b;
    int unsigned         pick;
    int unsigned         count;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        row_typed     = DIRECTED[i].typed;
        row_has_frame = DIRECTED[i].has_frame;
        row_bits      = DIRECTED[i].bits;
        send_pair(DIRECTED[i].first, DIRECTED[i].second);
      end
    end
    row_typed = 1'b0;

    while (pairs_taken < PAIR_TARGET) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_reg(CFG_CEILING, pick_reg_value());
      if ($urandom_range(0, 1)) write_reg(CFG_LONG, pick_reg_value());
      if ($urandom_range(0, 1)) write_reg(CFG_SHORT, pick_reg_value());
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, BYTE_W'($urandom));
      count = $urandom_range(20, 70);
      repeat (count) begin
        pick = $urandom_range(0, 19);
        if (pick < 4) begin
          a = last_first;
          b = last_second;
        end else if (pick < 6) begin
          a = last_first ^ (COLOUR_W'(1) << $urandom_range(0, COLOUR_W - 1));
          b = last_second;
        end else if (pick < 7) begin
          a = $urandom_range(0, 1) ? '1 : '0;
          b = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          a = COLOUR_W'($urandom);
          b = COLOUR_W'($urandom);
        end
        send_pair(a, b);
      end
    end

    wait_idle();
    repeat (4 * DRAIN_SLACK) @(negedge clk);
    if (pulse_q.size() != 0) begin
      errors++;
      $error("%0d pulse words never arrived", pulse_q.size());
    end
    $display("%0d colour pairs taken: %0d frames encoded, %0d repeated pairs dropped",
             pairs_taken, frames_taken, repeats_seen);
    $display("%0d pulse words checked across %0d register writes, one long output hold-off",
             pulses_seen, reg_writes);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
